// ===== sv/dmca_pkg.sv =====
// shared constants for the direct-mapped count accumulator
// field widths, item codes and register reset value; no dependencies
`default_nettype none
package dmca_pkg;

   localparam int KEY_W = 64;
   localparam int COUNT_W = 64;
   localparam int FLUSH_IDX_W = 10;
   localparam int CSR_W = 11;
   localparam int HALF_SHIFT = 32;
   localparam int MAX_BUCKETS_DEFAULT = 1024;

   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

endpackage
`default_nettype wire

// ===== sv/dmca_mod_unit.sv =====
// iterative remainder unit: 64-bit dividend modulo a small modulus, two bits per cycle
// depends on dmca_pkg
`default_nettype none
module dmca_mod_unit #(
   parameter int MAX_BUCKETS = dmca_pkg::MAX_BUCKETS_DEFAULT,
   localparam int MW = $clog2(MAX_BUCKETS + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [dmca_pkg::KEY_W-1:0]  dividend,
   input  wire logic [MW-1:0]               modulus,
   output logic                             done,
   output logic [MW-1:0]                    remainder
);

   localparam int STEPS = dmca_pkg::KEY_W / 2;
   localparam int CW = $clog2(STEPS);

   logic                       busy_ff;
   logic                       done_ff;
   logic [CW-1:0]              cnt_ff;
   logic [dmca_pkg::KEY_W-1:0] num_ff;
   logic [MW-1:0]              rem_ff;
   logic [MW-1:0]              mod_ff;
   logic [MW:0]                t1;
   logic [MW:0]                t2;
   logic [MW-1:0]              r1;
   logic [MW-1:0]              rem_in;

   // two restoring steps per cycle
   always_comb begin
      t1 = {rem_ff, num_ff[dmca_pkg::KEY_W-1]};
      if (t1 >= {1'b0, mod_ff}) begin
         t1 = t1 - {1'b0, mod_ff};
      end
      r1 = t1[MW-1:0];
      t2 = {r1, num_ff[dmca_pkg::KEY_W-2]};
      if (t2 >= {1'b0, mod_ff}) begin
         t2 = t2 - {1'b0, mod_ff};
      end
      rem_in = t2[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         mod_ff <= modulus;
      end else if (busy_ff) begin
         num_ff <= {num_ff[dmca_pkg::KEY_W-3:0], 2'b00};
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== sv/dmca_bucket_ram.sv =====
// bucket storage: key and count arrays, one write and one registered read per cycle
// depends on dmca_pkg
`default_nettype none
module dmca_bucket_ram #(
   parameter int DEPTH = dmca_pkg::MAX_BUCKETS_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [AW-1:0]                 rd_addr,
   output logic [dmca_pkg::KEY_W-1:0]         rd_key,
   output logic [dmca_pkg::COUNT_W-1:0]       rd_count,
   input  wire logic                          wr_en,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire logic [dmca_pkg::KEY_W-1:0]    wr_key,
   input  wire logic [dmca_pkg::COUNT_W-1:0]  wr_count
);

   logic [dmca_pkg::KEY_W-1:0]   key_mem [DEPTH];
   logic [dmca_pkg::COUNT_W-1:0] cnt_mem [DEPTH];
   logic [dmca_pkg::KEY_W-1:0]   rd_key_ff;
   logic [dmca_pkg::COUNT_W-1:0] rd_count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         cnt_mem[wr_addr] <= wr_count;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_count_ff <= cnt_mem[rd_addr];
      end
   end

   assign rd_key = rd_key_ff;
   assign rd_count = rd_count_ff;

endmodule
`default_nettype wire

// ===== sv/direct_mapped_count_accumulator_unit.sv =====
// top level of the direct-mapped count accumulator: control, hashing and bucket update
// depends on dmca_pkg, dmca_mod_unit and dmca_bucket_ram
//
// channel   ports                                   handshake
// input     req_mode req_key req_count              start high, busy low
//           req_flush_index
// result    rsp_out_key rsp_out_count               rsp_valid, one cycle, no stall
//           rsp_from_flush
// config    csr_wdata                               csr_we
//
// an add item holds busy through the remainder unit (32 steps of two hash bits each,
// then its done flag), one bucket read and one write back
// a flush item holds busy for a read and write back; an out-of-range index is dropped
// the result shows in the same cycle that busy falls; the receiver cannot stall it
// after reset busy stays high while the table is zeroed
// one item is in flight at a time, so the read-modify-write never overlaps
`default_nettype none
module direct_mapped_count_accumulator_unit #(
   parameter int MAX_BUCKETS = dmca_pkg::MAX_BUCKETS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_mode,
   input  wire logic [dmca_pkg::KEY_W-1:0]        req_key,
   input  wire logic signed [dmca_pkg::COUNT_W-1:0] req_count,
   input  wire logic [dmca_pkg::FLUSH_IDX_W-1:0]  req_flush_index,
   output logic                                   rsp_valid,
   output logic [dmca_pkg::KEY_W-1:0]             rsp_out_key,
   output logic signed [dmca_pkg::COUNT_W-1:0]    rsp_out_count,
   output logic                                   rsp_from_flush,
   input  wire logic                              csr_we,
   input  wire logic [dmca_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int MW = $clog2(MAX_BUCKETS + 1);
   localparam int IW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_WRITE
   } state_type;

   state_type                      state_ff;
   logic [IW-1:0]                  clr_ff;
   logic [IW-1:0]                  idx_ff;
   logic                           mode_ff;
   logic [dmca_pkg::KEY_W-1:0]     key_ff;
   logic [dmca_pkg::COUNT_W-1:0]   count_ff;
   logic                           rsp_valid_ff;
   logic [dmca_pkg::KEY_W-1:0]     rsp_key_ff;
   logic signed [dmca_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                           rsp_flush_ff;
   logic [dmca_pkg::CSR_W-1:0]     csr_ff;

   logic                           accept;
   logic                           div_start;
   logic                           div_done;
   logic [MW-1:0]                  div_rem;
   logic [MW-1:0]                  eff_mod;
   logic [dmca_pkg::KEY_W-1:0]     hash;
   logic                           flush_ok;

   logic                           mem_rd_en;
   logic [dmca_pkg::KEY_W-1:0]     mem_rd_key;
   logic [dmca_pkg::COUNT_W-1:0]   mem_rd_count;
   logic                           mem_wr_en;
   logic [IW-1:0]                  mem_wr_addr;
   logic [dmca_pkg::KEY_W-1:0]     mem_wr_key;
   logic [dmca_pkg::COUNT_W-1:0]   mem_wr_count;

   logic                           emit;
   logic [dmca_pkg::KEY_W-1:0]     new_key;
   logic [dmca_pkg::COUNT_W-1:0]   new_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= dmca_pkg::CSR_RESET;
      end else if (csr_we) begin
         csr_ff <= csr_wdata;
      end
   end

   // modulus zero acts as one, above the table size acts as the table size
   always_comb begin
      if (csr_ff == '0) begin
         eff_mod = MW'(1);
      end else if (32'(csr_ff) > 32'(MAX_BUCKETS)) begin
         eff_mod = MW'(MAX_BUCKETS);
      end else begin
         eff_mod = MW'(csr_ff);
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign hash = req_key ^ (req_key >> dmca_pkg::HALF_SHIFT);
   assign div_start = accept && (req_mode == dmca_pkg::MODE_ADD);
   assign flush_ok = 32'(req_flush_index) < 32'(MAX_BUCKETS);

   dmca_mod_unit #(
      .MAX_BUCKETS(MAX_BUCKETS)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (hash),
      .modulus  (eff_mod),
      .done     (div_done),
      .remainder(div_rem)
   );

   assign mem_rd_en = (state_ff == ST_READ);

   dmca_bucket_ram #(
      .DEPTH(MAX_BUCKETS)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_key  (mem_rd_key),
      .rd_count(mem_rd_count),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_key  (mem_wr_key),
      .wr_count(mem_wr_count)
   );

   // bucket update
   always_comb begin
      if (mode_ff == dmca_pkg::MODE_FLUSH) begin
         emit = (mem_rd_count != '0);
         new_key = mem_rd_key;
         new_count = '0;
      end else if (mem_rd_key == key_ff) begin
         emit = 1'b0;
         new_key = key_ff;
         new_count = mem_rd_count + count_ff;
      end else begin
         emit = (mem_rd_count != '0);
         new_key = key_ff;
         new_count = count_ff;
      end
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_wr_en = 1'b1;
         mem_wr_addr = clr_ff;
         mem_wr_key = '0;
         mem_wr_count = '0;
      end else begin
         mem_wr_en = (state_ff == ST_WRITE);
         mem_wr_addr = idx_ff;
         mem_wr_key = new_key;
         mem_wr_count = new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + IW'(1);
               if (clr_ff == IW'(MAX_BUCKETS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  mode_ff <= req_mode;
                  key_ff <= req_key;
                  count_ff <= req_count;
                  if (req_mode == dmca_pkg::MODE_ADD) begin
                     state_ff <= ST_DIV;
                  end else if (flush_ok) begin
                     idx_ff <= IW'(req_flush_index);
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  idx_ff <= div_rem[IW-1:0];
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               rsp_valid_ff <= emit;
               rsp_key_ff <= mem_rd_key;
               rsp_count_ff <= mem_rd_count;
               rsp_flush_ff <= mode_ff;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_key = rsp_key_ff;
   assign rsp_out_count = rsp_count_ff;
   assign rsp_from_flush = rsp_flush_ff;

endmodule
`default_nettype wire

// ===== sv/dmca_checker.sv =====
// port-level checks for the direct-mapped count accumulator, bound to the top level
// depends on dmca_pkg and direct_mapped_count_accumulator_unit
`default_nettype none
module dmca_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              req_mode,
   input wire logic                              rsp_valid,
   input wire logic [dmca_pkg::COUNT_W-1:0]      rsp_out_count
);

   // table clear runs right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("not busy after reset");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in a row");

   a_rsp_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in flight");

   a_rsp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_count != '0))
      else $error("zero count emitted");

   a_add_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == dmca_pkg::MODE_ADD)) |=> busy)
      else $error("add item accepted but not busy");

endmodule

bind direct_mapped_count_accumulator_unit dmca_checker u_dmca_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_mode     (req_mode),
   .rsp_valid    (rsp_valid),
   .rsp_out_count(rsp_out_count)
);
`default_nettype wire
